### hw/rtl/sl_packet_header_parser_macros.svh
// Assertion macros used by the sync-layer parser controller RTL.
`ifndef SL_PACKET_HEADER_PARSER_MACROS_SVH
`define SL_PACKET_HEADER_PARSER_MACROS_SVH

// Implication or plain property, sampled on clk_i, off during reset.
`define SLP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen.
`define SLP_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hw/rtl/slphp_pkg.sv
// Shared types and constants of the sync-layer packet header parser.
package slphp_pkg;

  localparam int unsigned DefMaxPacketBytes = 65535;
  localparam int unsigned HdrStoreBytes     = 128;
  localparam int unsigned HdrIdxW           = $clog2(HdrStoreBytes);
  localparam int unsigned BitPosW           = 10;   // longest header is at most 789 bits
  localparam logic [19:0] TicksPerSecond    = 20'd1000000;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE_FLAGS = 3'd0,
    CFG_TS_RES       = 3'd1,
    CFG_TS_LEN       = 3'd2,
    CFG_OCR_LEN      = 3'd3,
    CFG_AU_LEN_BITS  = 3'd4,
    CFG_RATE_LEN     = 3'd5,
    CFG_SEQ_LENS     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [5:0]  enable_flags;
    logic [31:0] ts_res;
    logic [6:0]  ts_len;
    logic [6:0]  ocr_len;
    logic [5:0]  au_len_bits;
    logic [7:0]  rate_len;
    logic [13:0] seq_lens;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    enable_flags: 6'd16,
    ts_res:       32'd1000,
    ts_len:       7'd32,
    ocr_len:      7'd0,
    au_len_bits:  6'd0,
    rate_len:     8'd0,
    seq_lens:     14'd0
  };

  // enable_flags bit positions
  localparam int unsigned EnAuStart = 0;
  localparam int unsigned EnAuEnd   = 1;
  localparam int unsigned EnRandAcc = 2;
  localparam int unsigned EnPadding = 3;
  localparam int unsigned EnTstamp  = 4;
  localparam int unsigned EnIdle    = 5;

  typedef struct packed {
    logic       byte_we;
    logic       parse_start;
    logic       fe_start;
    logic [7:0] fe_len;
    logic       cap_dts;
    logic       cap_cts;
    logic       sc_start;
    logic       sc_sel;     // 0 DTS, 1 CTS
    logic       sc_en;
    logic       load_out;
    logic       au_start;
    logic       au_end;
    logic       pad_all;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fe_busy;
    logic fe_bit;
    logic pad_nz;
    logic sc_busy;
    logic out_full;
  } dp_sts_t;

endpackage

### hw/rtl/slphp_datapath.sv
// Datapath: header byte store, bit reader, timestamp scaler and result register.
module slphp_datapath #(
  parameter int unsigned MAX_PACKET_BYTES = slphp_pkg::DefMaxPacketBytes
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  slphp_pkg::ctrl_cmd_t  cmd_i,
  output slphp_pkg::dp_sts_t    sts_o,
  input  logic [7:0]            data_byte_i,
  input  logic [31:0]           ts_res_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output logic                  au_start_o,
  output logic                  au_end_o,
  output logic [63:0]           decode_time_o,
  output logic [63:0]           present_time_o,
  output logic [15:0]           header_bytes_o
);
  import slphp_pkg::*;

  localparam int unsigned LimitInt = (MAX_PACKET_BYTES < 65535) ? MAX_PACKET_BYTES : 65535;
  localparam logic [15:0] Limit    = 16'(LimitInt);

  typedef enum logic [1:0] {SC_MUL, SC_SUM, SC_DIV} sc_e;

  logic [7:0]         mem [HdrStoreBytes];
  logic [7:0]         rd_q;
  logic [15:0]        byte_cnt_q;
  logic [BitPosW-1:0] bitpos_q;
  logic               fe_busy_q, fe_ph_q;
  logic [7:0]         fe_left_q;
  logic [63:0]        shift_q;
  logic [63:0]        dts_raw_q, cts_raw_q;
  logic [63:0]        dts_res_q, cts_res_q;
  logic               sc_busy_q, sc_sel_q;
  sc_e                sc_st_q;
  logic [51:0]        plo_q;
  logic [31:0]        phi_q;
  logic [63:0]        quo_q;
  logic [31:0]        rem_q;
  logic [5:0]         div_cnt_q;
  logic               out_valid_q;

  logic               cur_bit;
  logic [63:0]        raw_sel;
  logic [32:0]        trial;
  logic               qbit;
  logic [31:0]        rem_nxt;
  logic [63:0]        quo_nxt;
  logic [7:0]         hb_bits;
  logic [15:0]        hb_val;

  always_comb begin
    cur_bit = (16'(bitpos_q[BitPosW-1:3]) < byte_cnt_q) & rd_q[3'd7 - bitpos_q[2:0]];
    raw_sel = sc_sel_q ? cts_raw_q : dts_raw_q;
    trial   = {rem_q, quo_q[63]};
    qbit    = (trial >= {1'b0, ts_res_i});
    rem_nxt = qbit ? 32'(trial - {1'b0, ts_res_i}) : trial[31:0];
    quo_nxt = {quo_q[62:0], qbit};
    hb_bits = 8'(({1'b0, bitpos_q} + 11'd7) >> 3);
    if (cmd_i.pad_all) begin
      hb_val = byte_cnt_q;
    end else if (16'(hb_bits) > byte_cnt_q) begin
      hb_val = byte_cnt_q;
    end else begin
      hb_val = 16'(hb_bits);
    end
  end

  // header store, read every cycle at the current bit's byte
  always_ff @(posedge clk_i) begin
    if (cmd_i.byte_we && (byte_cnt_q < 16'(HdrStoreBytes))) begin
      mem[byte_cnt_q[HdrIdxW-1:0]] <= data_byte_i;
    end
    rd_q <= mem[bitpos_q[BitPosW-1:3]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_cnt_q <= '0;
      bitpos_q   <= '0;
      fe_busy_q  <= 1'b0;
      fe_ph_q    <= 1'b0;
      fe_left_q  <= '0;
      sc_busy_q  <= 1'b0;
      sc_sel_q   <= 1'b0;
      sc_st_q    <= SC_MUL;
      div_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load_out) begin
        byte_cnt_q <= '0;
      end else if (cmd_i.byte_we && (byte_cnt_q < Limit)) begin
        byte_cnt_q <= byte_cnt_q + 16'd1;
      end

      if (cmd_i.parse_start) begin
        bitpos_q <= '0;
      end else if (fe_busy_q && fe_ph_q) begin
        bitpos_q <= bitpos_q + BitPosW'(1);
      end

      if (cmd_i.fe_start) begin
        fe_busy_q <= 1'b1;
        fe_ph_q   <= 1'b0;
        fe_left_q <= cmd_i.fe_len;
      end else if (fe_busy_q) begin
        fe_ph_q <= ~fe_ph_q;
        if (fe_ph_q) begin
          fe_left_q <= fe_left_q - 8'd1;
          if (fe_left_q == 8'd1) fe_busy_q <= 1'b0;
        end
      end

      if (cmd_i.sc_start) begin
        sc_busy_q <= cmd_i.sc_en;
        sc_sel_q  <= cmd_i.sc_sel;
        sc_st_q   <= SC_MUL;
      end else if (sc_busy_q) begin
        unique case (sc_st_q)
          SC_MUL: sc_st_q <= SC_SUM;
          SC_SUM: begin
            sc_st_q   <= SC_DIV;
            div_cnt_q <= '0;
          end
          SC_DIV: begin
            div_cnt_q <= div_cnt_q + 6'd1;
            if (div_cnt_q == 6'd63) sc_busy_q <= 1'b0;
          end
          default: sc_st_q <= SC_MUL;
        endcase
      end

      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fe_start) begin
      shift_q <= '0;
    end else if (fe_busy_q && fe_ph_q) begin
      shift_q <= {shift_q[62:0], cur_bit};
    end
    if (cmd_i.parse_start) begin
      dts_raw_q <= '0;
      cts_raw_q <= '0;
    end else begin
      if (cmd_i.cap_dts) dts_raw_q <= shift_q;
      if (cmd_i.cap_cts) cts_raw_q <= shift_q;
    end

    if (cmd_i.sc_start && !cmd_i.sc_en) begin
      if (cmd_i.sc_sel) cts_res_q <= '0;
      else              dts_res_q <= '0;
    end else if (sc_busy_q) begin
      unique case (sc_st_q)
        SC_MUL: begin
          plo_q <= raw_sel[31:0] * TicksPerSecond;
          phi_q <= 32'(raw_sel[63:32] * TicksPerSecond);
        end
        SC_SUM: begin
          quo_q <= {12'd0, plo_q} + {phi_q, 32'd0};
          rem_q <= '0;
        end
        SC_DIV: begin
          quo_q <= quo_nxt;
          rem_q <= rem_nxt;
          if (div_cnt_q == 6'd63) begin
            if (sc_sel_q) cts_res_q <= quo_nxt + 64'd1;
            else          dts_res_q <= quo_nxt + 64'd1;
          end
        end
        default: ;
      endcase
    end

    if (cmd_i.load_out) begin
      au_start_o     <= cmd_i.au_start;
      au_end_o       <= cmd_i.au_end;
      decode_time_o  <= dts_res_q;
      present_time_o <= cts_res_q;
      header_bytes_o <= hb_val;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.fe_busy  = fe_busy_q;
  assign sts_o.fe_bit   = shift_q[0];
  assign sts_o.pad_nz   = (shift_q[2:0] != 3'd0);
  assign sts_o.sc_busy  = sc_busy_q;
  assign sts_o.out_full = out_valid_q & ~out_ready_i;

endmodule

### hw/rtl/slphp_ctrl.sv
// Controller: walks the header fields, then the two timestamp scalings.
`include "sl_packet_header_parser_macros.svh"

module slphp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  slphp_pkg::cfg_t      cfg_i,
  input  logic                 in_valid_i,
  input  logic                 is_last_i,
  output logic                 in_ready_o,
  output slphp_pkg::ctrl_cmd_t cmd_o,
  input  slphp_pkg::dp_sts_t   sts_i
);
  import slphp_pkg::*;

  typedef enum logic [2:0] {
    S_COLLECT, S_PHASE, S_WAIT, S_SC_DTS, S_SC_DWAIT, S_SC_CTS, S_SC_CWAIT, S_FINISH
  } state_e;

  typedef enum logic [4:0] {
    P_AUS, P_AUE, P_OCRF, P_IDLE, P_PADF, P_PADB, P_PKT, P_DPF, P_DP, P_OCR,
    P_RA, P_AUL, P_DTSF, P_CTSF, P_RATEF, P_DTS, P_CTS, P_AULEN, P_RATE
  } phase_e;

  state_e state_q;
  phase_e phase_q;
  logic   aus_q, aue_q, ocrf_q, idle_q, pad_q, padnz_q, dpf_q, dtsf_q, ctsf_q, ratef_q;

  logic       both_clear, aus_eff, aue_eff, body, accept, fe_done;
  logic [7:0] len;
  logic [3:0] dp_len;
  logic [4:0] pkt_len, au_len;

  always_comb begin
    dp_len     = cfg_i.seq_lens[13:10];
    pkt_len    = cfg_i.seq_lens[9:5];
    au_len     = cfg_i.seq_lens[4:0];
    both_clear = ~aus_q & ~aue_q;
    aus_eff    = aus_q | both_clear;
    aue_eff    = aue_q | both_clear;
    body       = ~idle_q & (~pad_q | padnz_q);
    accept     = in_valid_i & (state_q == S_COLLECT);
    fe_done    = (state_q == S_WAIT) & ~sts_i.fe_busy;

    unique case (phase_q)
      P_AUS:   len = 8'(cfg_i.enable_flags[EnAuStart]);
      P_AUE:   len = 8'(cfg_i.enable_flags[EnAuEnd]);
      P_OCRF:  len = 8'(cfg_i.ocr_len != 7'd0);
      P_IDLE:  len = 8'(cfg_i.enable_flags[EnIdle]);
      P_PADF:  len = 8'(cfg_i.enable_flags[EnPadding]);
      P_PADB:  len = pad_q ? 8'd3 : 8'd0;
      P_PKT:   len = body ? 8'(pkt_len) : 8'd0;
      P_DPF:   len = 8'(body && (dp_len != 4'd0));
      P_DP:    len = (body && dpf_q) ? 8'(dp_len) : 8'd0;
      P_OCR:   len = (body && ocrf_q) ? 8'(cfg_i.ocr_len) : 8'd0;
      P_RA:    len = 8'(body && aus_eff && cfg_i.enable_flags[EnRandAcc]);
      P_AUL:   len = (body && aus_eff) ? 8'(au_len) : 8'd0;
      P_DTSF,
      P_CTSF:  len = 8'(body && aus_eff && cfg_i.enable_flags[EnTstamp]);
      P_RATEF: len = 8'(body && aus_eff && (cfg_i.rate_len != 8'd0));
      P_DTS:   len = dtsf_q ? 8'(cfg_i.ts_len) : 8'd0;
      P_CTS:   len = ctsf_q ? 8'(cfg_i.ts_len) : 8'd0;
      P_AULEN: len = (body && aus_eff) ? 8'(cfg_i.au_len_bits) : 8'd0;
      P_RATE:  len = ratef_q ? cfg_i.rate_len : 8'd0;
      default: len = 8'd0;
    endcase

    in_ready_o        = (state_q == S_COLLECT);
    cmd_o             = '0;
    cmd_o.byte_we     = accept;
    cmd_o.parse_start = accept & is_last_i;
    cmd_o.fe_start    = (state_q == S_PHASE) & (len != 8'd0);
    cmd_o.fe_len      = len;
    cmd_o.cap_dts     = fe_done & (phase_q == P_DTS);
    cmd_o.cap_cts     = fe_done & (phase_q == P_CTS);
    cmd_o.sc_start    = (state_q == S_SC_DTS) | (state_q == S_SC_CTS);
    cmd_o.sc_sel      = (state_q == S_SC_CTS);
    cmd_o.sc_en       = ((state_q == S_SC_DTS) ? dtsf_q : ctsf_q) & (cfg_i.ts_res != 32'd0);
    cmd_o.load_out    = (state_q == S_FINISH) & ~sts_i.out_full;
    cmd_o.au_start    = aus_eff;
    cmd_o.au_end      = aue_eff;
    cmd_o.pad_all     = pad_q & ~padnz_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_COLLECT;
      phase_q <= P_AUS;
      aus_q   <= 1'b0;
      aue_q   <= 1'b0;
      ocrf_q  <= 1'b0;
      idle_q  <= 1'b0;
      pad_q   <= 1'b0;
      padnz_q <= 1'b0;
      dpf_q   <= 1'b0;
      dtsf_q  <= 1'b0;
      ctsf_q  <= 1'b0;
      ratef_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_COLLECT: begin
          if (accept && is_last_i) begin
            state_q <= S_PHASE;
            phase_q <= P_AUS;
            aus_q   <= 1'b0;
            aue_q   <= 1'b0;
            ocrf_q  <= 1'b0;
            idle_q  <= 1'b0;
            pad_q   <= 1'b0;
            padnz_q <= 1'b0;
            dpf_q   <= 1'b0;
            dtsf_q  <= 1'b0;
            ctsf_q  <= 1'b0;
            ratef_q <= 1'b0;
          end
        end
        S_PHASE: begin
          if (len != 8'd0) begin
            state_q <= S_WAIT;
          end else if (phase_q == P_RATE) begin
            state_q <= S_SC_DTS;
          end else begin
            phase_q <= phase_e'(phase_q + 5'd1);
          end
        end
        S_WAIT: begin
          if (!sts_i.fe_busy) begin
            unique case (phase_q)
              P_AUS:   aus_q   <= sts_i.fe_bit;
              P_AUE:   aue_q   <= sts_i.fe_bit;
              P_OCRF:  ocrf_q  <= sts_i.fe_bit;
              P_IDLE:  idle_q  <= sts_i.fe_bit;
              P_PADF:  pad_q   <= sts_i.fe_bit;
              P_PADB:  padnz_q <= sts_i.pad_nz;
              P_DPF:   dpf_q   <= sts_i.fe_bit;
              P_DTSF:  dtsf_q  <= sts_i.fe_bit;
              P_CTSF:  ctsf_q  <= sts_i.fe_bit;
              P_RATEF: ratef_q <= sts_i.fe_bit;
              default: ;
            endcase
            if (phase_q == P_RATE) begin
              state_q <= S_SC_DTS;
            end else begin
              state_q <= S_PHASE;
              phase_q <= phase_e'(phase_q + 5'd1);
            end
          end
        end
        S_SC_DTS:   state_q <= S_SC_DWAIT;
        S_SC_DWAIT: if (!sts_i.sc_busy) state_q <= S_SC_CTS;
        S_SC_CTS:   state_q <= S_SC_CWAIT;
        S_SC_CWAIT: if (!sts_i.sc_busy) state_q <= S_FINISH;
        S_FINISH:   if (!sts_i.out_full) state_q <= S_COLLECT;
        default:    state_q <= S_COLLECT;
      endcase
    end
  end

  `SLP_ASSERT(a_collect_idle, (state_q == S_COLLECT) |-> (!sts_i.fe_busy && !sts_i.sc_busy), "units busy while collecting")
  `SLP_ASSERT(a_fe_start_free, cmd_o.fe_start |-> !sts_i.fe_busy, "field read started while busy")
  `SLP_ASSERT_NEVER(a_sc_overlap, cmd_o.sc_start && sts_i.sc_busy, "scaler restarted while busy")
  `SLP_ASSERT(a_fe_runs, cmd_o.fe_start |=> sts_i.fe_busy, "field read did not start")

endmodule

### hw/rtl/sl_packet_header_parser.sv
// Sync-layer packet header parser: one byte per cycle while collecting a packet.
// After the last byte the header fields are read bit by bit, then DTS and CTS are
// scaled in turn on the shared 64-step radix-2 divider, then the result is loaded.
// Throughput: bytes accepted every cycle in collect; the packet end stalls the input
// for the parse and the shared divider. Reset: async active-low, config to defaults.
module sl_packet_header_parser #(
  parameter int unsigned MAX_PACKET_BYTES = slphp_pkg::DefMaxPacketBytes
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // packet bytes
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    data_byte_i,
  input  logic                          is_last_i,
  // one result per packet
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          au_start_o,
  output logic                          au_end_o,
  output logic [63:0]                   decode_time_o,
  output logic [63:0]                   present_time_o,
  output logic [15:0]                   header_bytes_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [slphp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [slphp_pkg::CfgDataW-1:0] cfg_data_i
);
  import slphp_pkg::*;

  cfg_t      cfg_q;
  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // register file; user must write only while idle (unenforced), else parse hazard
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ENABLE_FLAGS: cfg_q.enable_flags <= cfg_data_i[5:0];
        CFG_TS_RES:       cfg_q.ts_res       <= cfg_data_i[31:0];
        CFG_TS_LEN:       cfg_q.ts_len       <= cfg_data_i[6:0];
        CFG_OCR_LEN:      cfg_q.ocr_len      <= cfg_data_i[6:0];
        CFG_AU_LEN_BITS:  cfg_q.au_len_bits  <= cfg_data_i[5:0];
        CFG_RATE_LEN:     cfg_q.rate_len     <= cfg_data_i[7:0];
        CFG_SEQ_LENS:     cfg_q.seq_lens     <= cfg_data_i[13:0];
        default: ;  // unused index: write dropped
      endcase
    end
  end

  // field sequencing and handshakes
  slphp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .is_last_i  (is_last_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // byte store, bit reader, scaler, result register
  slphp_datapath #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .data_byte_i    (data_byte_i),
    .ts_res_i       (cfg_q.ts_res),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .au_start_o     (au_start_o),
    .au_end_o       (au_end_o),
    .decode_time_o  (decode_time_o),
    .present_time_o (present_time_o),
    .header_bytes_o (header_bytes_o)
  );

endmodule
